// ===== rtl/tchs_pkg.sv =====
// Package for the touch contact hold-and-scale block.
// Holds field widths, display constants, register indexes, poll codes and shared types.
// No dependencies.
package tchs_pkg;

   localparam int RAW_W   = 12;
   localparam int POS_W   = 9;
   localparam int STALE_W = 8;
   localparam int CNT_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [RAW_W-1:0] DISPLAY_WIDTH  = 12'd480;
   localparam logic [RAW_W-1:0] DISPLAY_HEIGHT = 12'd272;
   localparam logic [RAW_W-1:0] POS_LIMIT      = 12'd511;
   localparam logic [STALE_W-1:0] STALE_MAX    = 8'd255;

   localparam logic [RAW_W-1:0]   SENSOR_WIDTH_RST  = 12'd480;
   localparam logic [RAW_W-1:0]   SENSOR_HEIGHT_RST = 12'd272;
   localparam logic [STALE_W-1:0] STALE_LIMIT_RST   = 8'd40;

   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(RAW_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSOR_WIDTH  = 2'd0,
      CSR_SENSOR_HEIGHT = 2'd1,
      CSR_STALE_LIMIT   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      POLL_READ    = 2'd0,
      POLL_RELEASE = 2'd1,
      POLL_STALE   = 2'd2
   } poll_status_type;

   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] pos;
   } axis_result_type;

endpackage

// ===== rtl/tchs_axis.sv =====
// One coordinate lane: bit-serial shift-add multiply by the display size,
// then a restoring divide by the sensor resolution, one bit per cycle.
// Depends on tchs_pkg.
module tchs_axis
   import tchs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAW_W-1:0] raw,
   input  logic [RAW_W-1:0] res,
   input  logic [RAW_W-1:0] disp,
   output axis_result_type  result
);

   typedef enum logic [2:0] {
      AX_IDLE = 3'b001,
      AX_MUL  = 3'b010,
      AX_DIV  = 3'b100
   } axis_phase_type;

   axis_phase_type     phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RAW_W-1:0]   mpl_ff, mpl_in;
   logic [2*RAW_W-1:0] acc_ff, acc_in;
   logic [RAW_W-1:0]   res_ff, res_in;
   logic               sat_ff, sat_in;
   logic               done_ff, done_in;

   logic [RAW_W:0]     div_top;
   logic [RAW_W:0]     div_diff;
   logic               div_ge;
   logic [RAW_W-1:0]   quot;

   // partial remainder with the next dividend bit appended
   assign div_top  = {acc_ff[2*RAW_W-1:RAW_W], acc_ff[RAW_W-1]};
   assign div_ge   = div_top >= {1'b0, res_ff};
   assign div_diff = div_top - {1'b0, res_ff};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      mpl_in   = mpl_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      sat_in   = sat_ff;
      done_in  = done_ff;
      case (phase_ff)
         AX_IDLE: begin
            if (start) begin
               mpl_in   = raw;
               acc_in   = '0;
               res_in   = res;
               sat_in   = (res == '0) || (raw >= res);
               cnt_in   = '0;
               done_in  = 1'b0;
               phase_in = AX_MUL;
            end
         end
         AX_MUL: begin
            // shift-add, multiplier bits MSB first
            acc_in = {acc_ff[2*RAW_W-2:0], 1'b0}
                     + (mpl_ff[RAW_W-1] ? {{RAW_W{1'b0}}, disp} : '0);
            mpl_in = {mpl_ff[RAW_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               cnt_in   = '0;
               phase_in = AX_DIV;
            end
         end
         AX_DIV: begin
            // remainder stays below res, so it fits the upper half
            acc_in = {(div_ge ? div_diff[RAW_W-1:0] : div_top[RAW_W-1:0]),
                      acc_ff[RAW_W-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               cnt_in   = '0;
               done_in  = 1'b1;
               phase_in = AX_IDLE;
            end
         end
         default: begin
            phase_in = AX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= AX_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mpl_ff <= mpl_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   // out of range raw snaps to the display edge, then clamp to the field
   assign quot        = sat_ff ? disp : acc_ff[RAW_W-1:0];
   assign result.done = done_ff && (phase_ff == AX_IDLE);
   assign result.pos  = (quot > POS_LIMIT) ? POS_LIMIT[POS_W-1:0] : quot[POS_W-1:0];

endmodule

// ===== rtl/touch_contact_hold_and_scale.sv =====
// Top level of the touch contact hold-and-scale block: control registers,
// poll sequencing, contact/stale tracking and the result register.
// Depends on tchs_pkg and tchs_axis.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_poll_status/raw | in
//   rsp     | rsp_valid rsp_stall rsp_pressed/x/y_pos | out
//   csr     | csr_write_en csr_index csr_wdata        | in
//
// A point read goes from acceptance to the result register through accept,
// 12 shift-add steps and 12 restoring-divide steps in each axis lane, which
// run side by side, and finish. Any other poll goes from accept to finish.
// Reset is synchronous and loads the register defaults and clears the contact.
// A new transaction is taken while the previous result waits on rsp_stall; it
// then holds in its finish step until the result register frees up.
module touch_contact_hold_and_scale
   import tchs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_poll_status,
   input  logic [RAW_W-1:0]     req_raw_x,
   input  logic [RAW_W-1:0]     req_raw_y,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_pressed,
   output logic [POS_W-1:0]     rsp_x_pos,
   output logic [POS_W-1:0]     rsp_y_pos,

   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RAW_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CALC   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           status_ff, status_in;
   logic [RAW_W-1:0]     sens_w_ff, sens_h_ff;
   logic [STALE_W-1:0]   stale_limit_ff;

   logic                 contact_ff, contact_in;
   logic [POS_W-1:0]     held_x_ff, held_x_in;
   logic [POS_W-1:0]     held_y_ff, held_y_in;
   logic [STALE_W-1:0]   stale_ff, stale_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pressed_ff;
   logic [POS_W-1:0]     rsp_x_ff, rsp_y_ff;

   logic                 req_fire;
   logic                 fin_fire;
   logic                 start;
   logic [STALE_W-1:0]   stale_inc;
   axis_result_type      ax_x, ax_y;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign fin_fire  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign start     = req_fire && (req_poll_status == POLL_READ);

   tchs_axis u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .raw    (req_raw_x),
      .res    (sens_w_ff),
      .disp   (DISPLAY_WIDTH),
      .result (ax_x)
   );

   tchs_axis u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .raw    (req_raw_y),
      .res    (sens_h_ff),
      .disp   (DISPLAY_HEIGHT),
      .result (ax_y)
   );

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in = req_poll_status;
               state_in  = (req_poll_status == POLL_READ) ? ST_CALC : ST_FINISH;
            end
         end
         ST_CALC: begin
            if (ax_x.done && ax_y.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fin_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign stale_inc = (stale_ff == STALE_MAX) ? stale_ff : stale_ff + 1'b1;

   always_comb begin
      contact_in = contact_ff;
      held_x_in  = held_x_ff;
      held_y_in  = held_y_ff;
      stale_in   = stale_ff;
      if (fin_fire) begin
         case (status_ff)
            POLL_READ: begin
               contact_in = 1'b1;
               held_x_in  = ax_x.pos;
               held_y_in  = ax_y.pos;
               stale_in   = '0;
            end
            POLL_RELEASE: begin
               contact_in = 1'b0;
               stale_in   = '0;
            end
            default: begin
               // stale poll: count, and drop the contact past the limit
               stale_in = stale_inc;
               if (stale_inc > stale_limit_ff) begin
                  contact_in = 1'b0;
               end
            end
         endcase
      end
   end

   assign rsp_valid_in = fin_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         contact_ff     <= 1'b0;
         held_x_ff      <= '0;
         held_y_ff      <= '0;
         stale_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         sens_w_ff      <= SENSOR_WIDTH_RST;
         sens_h_ff      <= SENSOR_HEIGHT_RST;
         stale_limit_ff <= STALE_LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         contact_ff   <= contact_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_SENSOR_WIDTH:  sens_w_ff      <= csr_wdata;
               CSR_SENSOR_HEIGHT: sens_h_ff      <= csr_wdata;
               CSR_STALE_LIMIT:   stale_limit_ff <= csr_wdata[STALE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (fin_fire) begin
         rsp_pressed_ff <= contact_in;
         rsp_x_ff       <= held_x_in;
         rsp_y_ff       <= held_y_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pressed = rsp_pressed_ff;
   assign rsp_x_pos   = rsp_x_ff;
   assign rsp_y_pos   = rsp_y_ff;

`ifndef NO_ASSERTIONS
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_lanes_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status_ff == POLL_READ) |-> (ax_x.done && ax_y.done))
      else $error("finish on a point read before both lanes are done");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not leave idle");

   a_read_presses: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && status_ff == POLL_READ) |=> (rsp_valid && rsp_pressed))
      else $error("point read did not report a press");
`endif

endmodule
